// ----- src/text_console_char_writer_assert.svh -----
// ----------------------------------------------------------------------------
// Text console character writer - assertion macros
// Concurrent checks sampled on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

// same-cycle implication
`define TCCW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCCW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console character writer - package
// Geometry, field widths, codes and the tab stop table.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CELL_W = $clog2(CELLS);
    localparam int RN_W   = $clog2(ROWS + 1);
    localparam int CN_W   = $clog2(COLUMNS + TAB_WIDTH);

    localparam int ACTION_W   = 2;
    localparam int CHAR_W     = 8;
    localparam int RROW_W     = 5;
    localparam int RCOL_W     = 7;
    localparam int POS_W      = 11;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_FILL,
        ST_RESP
    } state_t;

    typedef logic [CN_W-1:0] tab_stop_t [COLUMNS];

    function automatic tab_stop_t build_tab_stops();
        tab_stop_t t;
        for (int i = 0; i < COLUMNS; i++) begin
            t[i] = CN_W'(((i / TAB_WIDTH) + 1) * TAB_WIDTH);
        end
        return t;
    endfunction

    localparam tab_stop_t TAB_STOP = build_tab_stops();

endpackage

`default_nettype wire

// ----- src/text_console_char_writer.sv -----
// Plain put, read and unused requests: after the handshake, ST_RESP loads m_tdata and
// raises m_tvalid once the output is free; a waiting result on m_tready delays this.
// A put that scrolls copies CELLS-COLUMNS cells through the store (one a cycle) and
// blanks the bottom row. Clear sweeps all CELLS cells.
// One request in flight; the next is accepted while a result still waits on m_tready.
// Reset: synchronous, active low; the store is then swept to spaces, s_tready low.
// ----------------------------------------------------------------------------
// Text console character writer
// 80x25 character store with cursor: put character, clear, read cell.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_char_writer_assert.svh"

module text_console_char_writer
    import tccw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // action[1:0], char_code[9:2], read_row[14:10], read_col[21:15], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // cursor_row[4:0], cursor_col[11:5], cursor_pos[22:12], read_char[30:23], zero pad
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic [CHAR_W-1:0] mem [CELLS];

    state_t              state_reg, state_next;
    logic [CELL_W-1:0]   cnt_reg, cnt_next;
    logic                cp_valid_reg, cp_valid_next;
    logic [CELL_W-1:0]   cp_addr_reg, cp_addr_next;
    logic [ROW_W-1:0]    cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0]    cursor_col_reg, cursor_col_next;
    logic                read_hit_reg, read_hit_next;
    logic [CHAR_W-1:0]   rd_data_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                mem_we, mem_re;
    logic [CELL_W-1:0]   mem_waddr, mem_raddr;
    logic [CHAR_W-1:0]   mem_wdata;

    logic                accept, out_free;
    logic [ACTION_W-1:0] in_action;
    logic [CHAR_W-1:0]   in_char;
    logic [RROW_W-1:0]   in_rrow;
    logic [RCOL_W-1:0]   in_rcol;
    logic                in_read_ok;
    logic [CELL_W-1:0]   in_read_addr;

    logic [RN_W-1:0]     put_row;
    logic [CN_W-1:0]     put_col;
    logic                put_we;
    logic [ROW_W-1:0]    put_wrow;
    logic [COL_W-1:0]    put_wcol;
    logic [CHAR_W-1:0]   put_wdata;
    logic                put_scroll;
    logic [ROW_W-1:0]    put_row_fin;
    logic [COL_W-1:0]    put_col_fin;
    logic [CELL_W-1:0]   put_addr;

    logic [POS_W-1:0]    out_pos;
    logic [CHAR_W-1:0]   out_char;

    assign in_action = s_tdata[1:0];
    assign in_char   = s_tdata[9:2];
    assign in_rrow   = s_tdata[14:10];
    assign in_rcol   = s_tdata[21:15];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_read_ok   = (32'(in_rrow) < ROWS) && (32'(in_rcol) < COLUMNS);
    assign in_read_addr = CELL_W'(in_rrow[ROW_W-1:0]) * CELL_W'(COLUMNS)
                          + CELL_W'(in_rcol[COL_W-1:0]);

    always_comb begin
        put_row   = RN_W'(cursor_row_reg);
        put_col   = CN_W'(cursor_col_reg);
        put_we    = 1'b0;
        put_wrow  = cursor_row_reg;
        put_wcol  = cursor_col_reg;
        put_wdata = in_char;
        case (in_char)
            CH_BS: begin
                put_we    = 1'b1;
                put_wdata = CH_BLANK;
                if (cursor_col_reg != '0) begin
                    put_col = CN_W'(cursor_col_reg) - CN_W'(1);
                end else begin
                    if (cursor_row_reg != '0) begin
                        put_row = RN_W'(cursor_row_reg) - RN_W'(1);
                    end
                    put_col  = CN_W'(COLUMNS - 1);
                    put_wrow = put_row[ROW_W-1:0];
                    put_wcol = COL_W'(COLUMNS - 1);
                end
            end
            CH_TAB: begin
                put_col = TAB_STOP[cursor_col_reg];
            end
            CH_CR: begin
                put_col = '0;
            end
            CH_LF: begin
                put_col = '0;
                put_row = RN_W'(cursor_row_reg) + RN_W'(1);
            end
            default: begin
                if (in_char inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
                    put_we  = 1'b1;
                    put_col = CN_W'(cursor_col_reg) + CN_W'(1);
                end
            end
        endcase
        if (32'(put_col) >= COLUMNS) begin
            put_col = '0;
            put_row = put_row + RN_W'(1);
        end
        put_scroll = (32'(put_row) >= ROWS);
        put_row_fin = put_scroll ? ROW_W'(ROWS - 1) : put_row[ROW_W-1:0];
        put_col_fin = put_col[COL_W-1:0];
        put_addr = CELL_W'(put_wrow) * CELL_W'(COLUMNS) + CELL_W'(put_wcol);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (32'(cnt_reg) == CELLS - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_action == ACT_PUT) begin
                        state_next = put_scroll ? ST_SCROLL : ST_RESP;
                    end else if (in_action == ACT_CLEAR) begin
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCROLL: begin
                if (32'(cnt_reg) == CELLS - COLUMNS) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (32'(cnt_reg) == CELLS - 1) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    assign out_pos  = POS_W'(cursor_row_reg) * POS_W'(COLUMNS) + POS_W'(cursor_col_reg);
    assign out_char = read_hit_reg ? rd_data_reg : '0;

    always_comb begin
        cnt_next        = cnt_reg;
        cp_valid_next   = 1'b0;
        cp_addr_next    = cp_addr_reg;
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        read_hit_next   = read_hit_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg;
        mem_wdata       = CH_BLANK;
        mem_re          = 1'b0;
        mem_raddr       = in_read_addr;

        if (cp_valid_reg) begin
            mem_we    = 1'b1;
            mem_waddr = cp_addr_reg;
            mem_wdata = rd_data_reg;
        end

        case (state_reg)
            ST_INIT, ST_FILL: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + CELL_W'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    read_hit_next = 1'b0;
                    cnt_next      = '0;
                    if (in_action == ACT_PUT) begin
                        mem_we          = put_we;
                        mem_waddr       = put_addr;
                        mem_wdata       = put_wdata;
                        cursor_row_next = put_row_fin;
                        cursor_col_next = put_col_fin;
                    end else if (in_action == ACT_CLEAR) begin
                        cursor_row_next = '0;
                        cursor_col_next = '0;
                    end else if (in_action == ACT_READ) begin
                        mem_re        = in_read_ok;
                        read_hit_next = in_read_ok;
                    end
                end
            end
            ST_SCROLL: begin
                if (32'(cnt_reg) < CELLS - COLUMNS) begin
                    mem_re        = 1'b1;
                    mem_raddr     = cnt_reg + CELL_W'(COLUMNS);
                    cp_valid_next = 1'b1;
                    cp_addr_next  = cnt_reg;
                    cnt_next      = cnt_reg + CELL_W'(1);
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, out_char, out_pos,
                                     RCOL_W'(cursor_col_reg), RROW_W'(cursor_row_reg)};
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            cnt_reg        <= '0;
            cp_valid_reg   <= 1'b0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            read_hit_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cp_valid_reg   <= cp_valid_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            read_hit_reg   <= read_hit_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_addr_reg <= cp_addr_next;
        m_tdata_reg <= m_tdata_next;
    end

    `TCCW_ASSERT_IMP(a_cursor_in_range, state_reg == ST_IDLE,
        (32'(cursor_row_reg) < ROWS) && (32'(cursor_col_reg) < COLUMNS),
        "cursor outside the screen")
    `TCCW_ASSERT_IMP(a_copy_below_read, cp_valid_reg && mem_re,
        cp_addr_reg < mem_raddr, "scroll copy overtakes its source")
    `TCCW_ASSERT_NXT(a_one_in_flight, accept, state_reg != ST_IDLE,
        "second request taken while one is in flight")
    `TCCW_ASSERT_NXT(a_result_loaded, (state_reg == ST_RESP) && out_free, m_tvalid,
        "result not presented after completion")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console character writer - self-checking testbench
// Streams put, clear, read and unused requests into the console, predicts the
// cursor and the cell contents on its own copy of the 80x25 store, and checks
// every result field against that prediction, with random idling on both
// sides and one long back-pressure stretch on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import tccw_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1625;
    localparam int TAIL_ITEMS   = 200;
    localparam int HOLD_AFTER   = 500;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 12_000_000;
    localparam int MAX_PRINTS   = 30;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [CHAR_W-1:0]   code;
        logic [RROW_W-1:0]   rrow;
        logic [RCOL_W-1:0]   rcol;
    } console_req_t;

    typedef struct {
        logic [RROW_W-1:0] row;
        logic [RCOL_W-1:0] col;
        logic [POS_W-1:0]  pos;
        logic [CHAR_W-1:0] rd_char;
    } cursor_report_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    text_console_char_writer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    console_req_t   pending_reqs[$];
    cursor_report_t expected_reports[$];
    console_req_t   in_flight;

    logic [CHAR_W-1:0] screen [ROWS][COLUMNS];
    int cur_row, cur_col;

    int accepted_total, results_seen, error_count;
    int put_count, read_count, clear_count, scroll_count, odd_count;
    int src_gap, sink_gap, hold_left, hold_seen, cycle_count;
    bit hold_done;
    bit quiet_tail = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic console_req_t make_req(logic [ACTION_W-1:0] action,
                                              logic [CHAR_W-1:0] code,
                                              int rrow, int rcol);
        console_req_t q;
        q.action = action;
        q.code   = code;
        q.rrow   = rrow[RROW_W-1:0];
        q.rcol   = rcol[RCOL_W-1:0];
        return q;
    endfunction

    function automatic void wipe_screen();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLUMNS; c++)
                screen[r][c] = CH_BLANK;
        cur_row = 0;
        cur_col = 0;
    endfunction

    function automatic void put_byte(logic [CHAR_W-1:0] ch);
        int r;
        int c;
        r = cur_row;
        c = cur_col;
        if (ch == CH_BS) begin
            if (c > 0) begin
                screen[r][c] = CH_BLANK;
                c--;
            end else begin
                if (r > 0)
                    r--;
                c = COLUMNS - 1;
                screen[r][c] = CH_BLANK;
            end
        end else if (ch == CH_TAB) begin
            c = (c / TAB_WIDTH + 1) * TAB_WIDTH;
        end else if (ch == CH_CR) begin
            c = 0;
        end else if (ch == CH_LF) begin
            c = 0;
            r++;
        end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
            screen[r][c] = ch;
            c++;
        end
        if (c >= COLUMNS) begin
            c = 0;
            r++;
        end
        if (r >= ROWS) begin
            for (int rr = 0; rr < ROWS - 1; rr++)
                for (int cc = 0; cc < COLUMNS; cc++)
                    screen[rr][cc] = screen[rr + 1][cc];
            for (int cc = 0; cc < COLUMNS; cc++)
                screen[ROWS - 1][cc] = CH_BLANK;
            r = ROWS - 1;
            scroll_count++;
        end
        cur_row = r;
        cur_col = c;
    endfunction

    function automatic cursor_report_t apply_request(console_req_t q);
        cursor_report_t rep;
        int pos;
        rep.rd_char = '0;
        case (q.action)
            ACT_PUT: begin
                put_byte(q.code);
                put_count++;
            end
            ACT_CLEAR: begin
                wipe_screen();
                clear_count++;
            end
            ACT_READ: begin
                if (q.rrow < ROWS && q.rcol < COLUMNS)
                    rep.rd_char = screen[q.rrow][q.rcol];
                read_count++;
            end
            default: odd_count++;
        endcase
        pos = cur_row * COLUMNS + cur_col;
        rep.row = cur_row[RROW_W-1:0];
        rep.col = cur_col[RCOL_W-1:0];
        rep.pos = pos[POS_W-1:0];
        return rep;
    endfunction

    function automatic console_req_t random_req();
        int pick;
        int sel;
        logic [CHAR_W-1:0] ch;
        pick = $urandom_range(0, 999);
        if (pick < 3)
            return make_req(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)),
                            $urandom_range(0, 31), $urandom_range(0, 127));
        if (pick < 23)
            return make_req(ACT_UNUSED, CHAR_W'($urandom_range(0, 255)),
                            $urandom_range(0, 31), $urandom_range(0, 127));
        if (pick < 243) begin
            if ($urandom_range(0, 9) == 0)
                return make_req(ACT_READ, CHAR_W'($urandom_range(0, 255)),
                                $urandom_range(0, 31), $urandom_range(0, 127));
            return make_req(ACT_READ, CHAR_W'($urandom_range(0, 255)),
                            $urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
        end
        sel = $urandom_range(0, 99);
        if (sel < 66) begin
            ch = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
        end else if (sel < 76) begin
            ch = CH_LF;
        end else if (sel < 80) begin
            ch = CH_CR;
        end else if (sel < 87) begin
            ch = CH_TAB;
        end else if (sel < 94) begin
            ch = CH_BS;
        end else begin
            do
                ch = CHAR_W'($urandom_range(0, 255));
            while ((ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) || ch == CH_BS ||
                   ch == CH_TAB || ch == CH_LF || ch == CH_CR);
        end
        return make_req(ACT_PUT, ch, $urandom_range(0, 31), $urandom_range(0, 127));
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        if (error_count < MAX_PRINTS)
            $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
        error_count++;
    endtask

    // sender: offer pending requests, predict each one as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_reports.push_back(apply_request(in_flight));
                accepted_total++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    in_flight = pending_reqs.pop_front();
                    s_tdata   <= {2'b00, in_flight.rcol, in_flight.rrow,
                                  in_flight.code, in_flight.action};
                    s_tvalid  <= 1'b1;
                    if (pending_reqs.size() < TAIL_ITEMS)
                        quiet_tail <= 1'b1;
                    else if ($urandom_range(0, 3) == 0)
                        src_gap = $urandom_range(1, 13);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each result against the oldest prediction
    always @(posedge aclk) begin
        cursor_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected result, pending count", 0, 1);
                end else begin
                    want = expected_reports.pop_front();
                    if (m_tdata[4:0] != want.row)
                        report_mismatch("cursor_row", m_tdata[4:0], want.row);
                    if (m_tdata[11:5] != want.col)
                        report_mismatch("cursor_col", m_tdata[11:5], want.col);
                    if (m_tdata[22:12] != want.pos)
                        report_mismatch("cursor_pos", m_tdata[22:12], want.pos);
                    if (m_tdata[30:23] != want.rd_char)
                        report_mismatch("read_char", m_tdata[30:23], want.rd_char);
                end
                results_seen++;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 4) == 0)
                    sink_gap = $urandom_range(1, 13);
            end
        end
    end

    // hold off the result side once for a long stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_seen <= 0;
            hold_done <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                hold_seen <= hold_seen + 1;
            if (!hold_done && hold_seen >= HOLD_AFTER) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout: %0d requests taken, %0d results seen", accepted_total,
                     results_seen);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        wipe_screen();

        pending_reqs.push_back(make_req(ACT_PUT, 8'h41, 0, 0));
        pending_reqs.push_back(make_req(ACT_PUT, CH_PRINT_HI, 0, 0));
        pending_reqs.push_back(make_req(ACT_PUT, CH_PRINT_LO, 0, 0));
        pending_reqs.push_back(make_req(ACT_READ, 8'h00, 0, 0));
        pending_reqs.push_back(make_req(ACT_READ, 8'hFF, ROWS - 1, COLUMNS - 1));
        pending_reqs.push_back(make_req(ACT_READ, 8'h00, ROWS, 0));
        pending_reqs.push_back(make_req(ACT_READ, 8'h00, 31, 127));
        pending_reqs.push_back(make_req(ACT_READ, 8'h00, 0, COLUMNS));
        pending_reqs.push_back(make_req(ACT_PUT, CH_BS, 0, 0));
        pending_reqs.push_back(make_req(ACT_PUT, CH_CR, 0, 0));
        // backspace on the top row at column 0
        pending_reqs.push_back(make_req(ACT_PUT, CH_BS, 0, 0));
        // tab from the last column wraps to the next row
        pending_reqs.push_back(make_req(ACT_PUT, CH_TAB, 0, 0));
        pending_reqs.push_back(make_req(ACT_PUT, CH_TAB, 0, 0));
        pending_reqs.push_back(make_req(ACT_PUT, CH_LF, 0, 0));
        pending_reqs.push_back(make_req(ACT_PUT, CH_BS, 0, 0));
        pending_reqs.push_back(make_req(ACT_PUT, 8'h7A, 0, 0));
        pending_reqs.push_back(make_req(ACT_READ, 8'h00, 1, COLUMNS - 1));
        pending_reqs.push_back(make_req(ACT_PUT, 8'h00, 0, 0));
        pending_reqs.push_back(make_req(ACT_PUT, 8'h1F, 0, 0));
        pending_reqs.push_back(make_req(ACT_PUT, 8'h80, 0, 0));
        pending_reqs.push_back(make_req(ACT_PUT, 8'hFF, 0, 0));
        pending_reqs.push_back(make_req(ACT_UNUSED, 8'hFF, 31, 127));
        pending_reqs.push_back(make_req(ACT_CLEAR, 8'h00, 0, 0));
        pending_reqs.push_back(make_req(ACT_READ, 8'h00, 1, COLUMNS - 1));
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_reqs.push_back(random_req());

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d puts, %0d reads, %0d clears, %0d unused-code requests",
                 put_count, read_count, clear_count, odd_count);
        $display("screen scrolled %0d times; %0d results checked, %0d mismatches",
                 scroll_count, results_seen, error_count);
        if (error_count == 0 && expected_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
